// File: design/srld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_pkg
// Shared types and constants for the score run line decoder.
// ----------------------------------------------------------------------------
package srld_pkg;

	// Widths of the stream fields.
	localparam int ART_FIELD_W   = 31;
	localparam int CHAR_W        = 8;
	localparam int OP_W          = 2;
	localparam int SCORE_FIELD_W = 32;
	localparam int IN_DATA_W     = 40;
	localparam int OUT_DATA_W    = 96;

	// Default sizes of the internal arithmetic.
	localparam int SCORE_BITS_DEF   = 32;
	localparam int ARTICLE_BITS_DEF = 31;

	// Entries in the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Opcodes carried in tuser.
	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_CHAR = 2'd1;
	localparam logic [OP_W-1:0] OP_EOL  = 2'd2;

	// Characters of the score line.
	localparam logic [CHAR_W-1:0] CH_A    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
	localparam logic [CHAR_W-1:0] CH_J    = 8'h4A;
	localparam logic [CHAR_W-1:0] CH_S    = 8'h53;
	localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_REP  = 8'h72;
	localparam logic [CHAR_W-1:0] CH_SKIP = 8'h73;

	// What the front decided a beat is.
	typedef enum logic [3:0] {
		CLS_NOP   = 4'd0,
		CLS_LOAD  = 4'd1,
		CLS_EOL   = 4'd2,
		CLS_DIGIT = 4'd3,
		CLS_NEG   = 4'd4,
		CLS_POS   = 4'd5,
		CLS_REP   = 4'd6,
		CLS_SKIP  = 4'd7,
		CLS_OTHER = 4'd8
	} cls_t;

	// Kind of the token being built in the back.
	typedef enum logic [4:0] {
		KIND_NONE = 5'b00001,
		KIND_NEG  = 5'b00010,
		KIND_POS  = 5'b00100,
		KIND_REP  = 5'b01000,
		KIND_SKIP = 5'b10000
	} kind_t;

	// One classified beat as it travels from the front to the back.
	typedef struct packed {
		cls_t                   cls;
		logic [3:0]             digit;
		logic [ART_FIELD_W-1:0] article;
	} item_t;

endpackage

// File: design/srld_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_front
// Accepts input beats, classifies the character and registers the result.
// ----------------------------------------------------------------------------
module srld_front #(
	parameter int ARTICLE_BITS = srld_pkg::ARTICLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [srld_pkg::OP_W-1:0]        opcode,
	input  logic [srld_pkg::ART_FIELD_W-1:0] start_article,
	input  logic [srld_pkg::CHAR_W-1:0]      char_code,
	output logic                             item_valid,
	input  logic                             item_ready,
	output srld_pkg::item_t                  item
);

	localparam logic [srld_pkg::ART_FIELD_W:0] ART_MAX =
		(srld_pkg::ART_FIELD_W+1)'((64'd1 << ARTICLE_BITS) - 64'd1);

	srld_pkg::item_t cls_item;
	logic            valid_s1;
	srld_pkg::item_t item_s1;

	always_comb begin
		cls_item.cls     = srld_pkg::CLS_NOP;
		cls_item.digit   = 4'd0;
		cls_item.article = start_article;
		if ({1'b0, start_article} > ART_MAX) begin
			cls_item.article = ART_MAX[srld_pkg::ART_FIELD_W-1:0];
		end
		case (opcode)
			srld_pkg::OP_LOAD: cls_item.cls = srld_pkg::CLS_LOAD;
			srld_pkg::OP_EOL:  cls_item.cls = srld_pkg::CLS_EOL;
			srld_pkg::OP_CHAR: begin
				if (char_code inside {[srld_pkg::CH_0:srld_pkg::CH_9]}) begin
					cls_item.cls   = srld_pkg::CLS_DIGIT;
					cls_item.digit = 4'(char_code - srld_pkg::CH_0);
				end else if (char_code inside {[srld_pkg::CH_A:srld_pkg::CH_I]}) begin
					cls_item.cls   = srld_pkg::CLS_NEG;
					cls_item.digit = 4'(srld_pkg::CH_J - char_code);
				end else if (char_code inside {[srld_pkg::CH_J:srld_pkg::CH_S]}) begin
					cls_item.cls   = srld_pkg::CLS_POS;
					cls_item.digit = 4'(char_code - srld_pkg::CH_J);
				end else if (char_code == srld_pkg::CH_REP) begin
					cls_item.cls = srld_pkg::CLS_REP;
				end else if (char_code == srld_pkg::CH_SKIP) begin
					cls_item.cls = srld_pkg::CLS_SKIP;
				end else begin
					cls_item.cls = srld_pkg::CLS_OTHER;
				end
			end
			default: cls_item.cls = srld_pkg::CLS_NOP;
		endcase
	end

	assign in_ready = !valid_s1 || item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls_item;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// File: design/srld_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_queue
// Short first-in first-out queue of classified beats.
// ----------------------------------------------------------------------------
module srld_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  srld_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output srld_pkg::item_t pop_item
);

	localparam int PTR_W = $clog2(srld_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(srld_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(srld_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(srld_pkg::QUEUE_DEPTH - 1);

	srld_pkg::item_t  entry_q [srld_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != DEPTH_C);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// File: design/srld_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srld_back
// Executes classified beats against the token state and emits run records.
// ----------------------------------------------------------------------------
module srld_back #(
	parameter int SCORE_BITS   = srld_pkg::SCORE_BITS_DEF,
	parameter int ARTICLE_BITS = srld_pkg::ARTICLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  srld_pkg::item_t                     item,
	output logic                                rec_valid,
	input  logic                                rec_ready,
	output logic [srld_pkg::ART_FIELD_W-1:0]    first_article,
	output logic [srld_pkg::ART_FIELD_W-1:0]    run_length,
	output logic [srld_pkg::SCORE_FIELD_W-1:0]  score_value
);

	localparam int ACC_BITS = (SCORE_BITS - 1 > ARTICLE_BITS) ? SCORE_BITS - 1 : ARTICLE_BITS;
	localparam int EXT_BITS = ACC_BITS + 4;
	localparam logic [EXT_BITS-1:0] SCORE_LIM =
		EXT_BITS'((64'd1 << (SCORE_BITS - 1)) - 64'd1);
	localparam logic [EXT_BITS-1:0] COUNT_LIM =
		EXT_BITS'((64'd1 << ARTICLE_BITS) - 64'd1);

	srld_pkg::kind_t                kind_q;
	logic [ACC_BITS-1:0]            acc_q;
	logic                           digits_q;
	logic [ARTICLE_BITS-1:0]        cur_q;
	logic signed [SCORE_BITS-1:0]   last_q;

	logic                           out_valid_q;
	logic [srld_pkg::ART_FIELD_W-1:0]   out_first_q;
	logic [srld_pkg::ART_FIELD_W-1:0]   out_len_q;
	logic [srld_pkg::SCORE_FIELD_W-1:0] out_score_q;

	logic                           fire;
	logic                           is_score;
	logic [ARTICLE_BITS-1:0]        cnt;
	logic [ARTICLE_BITS-1:0]        adv;
	logic [ARTICLE_BITS:0]          sum;
	logic [ARTICLE_BITS-1:0]        cur_fin;
	logic [SCORE_BITS-1:0]          mag;
	logic signed [SCORE_BITS-1:0]   score_fin;
	logic                           emit;
	logic [EXT_BITS-1:0]            acc_ext;
	logic [EXT_BITS-1:0]            acc_lim;
	logic [ACC_BITS-1:0]            acc_dig;
	logic                           extend;

	assign item_ready = !out_valid_q || rec_ready;
	assign fire       = item_valid && item_ready;

	// Completion of the pending token: the record and the advanced article.
	always_comb begin
		is_score = (kind_q == srld_pkg::KIND_NEG) || (kind_q == srld_pkg::KIND_POS);
		if (is_score || !digits_q) begin
			cnt = ARTICLE_BITS'(1);
		end else begin
			cnt = ARTICLE_BITS'(acc_q);
		end
		adv     = (kind_q == srld_pkg::KIND_NONE) ? '0 : cnt;
		sum     = {1'b0, cur_q} + {1'b0, adv};
		cur_fin = sum[ARTICLE_BITS] ? '1 : sum[ARTICLE_BITS-1:0];
		mag     = SCORE_BITS'(acc_q);
		if (kind_q == srld_pkg::KIND_NEG) begin
			score_fin = -mag;
		end else if (kind_q == srld_pkg::KIND_POS) begin
			score_fin = mag;
		end else begin
			score_fin = last_q;
		end
		emit = is_score || ((kind_q == srld_pkg::KIND_REP) && (cnt != '0));
	end

	// Decimal extension of the pending magnitude or count, saturating.
	always_comb begin
		acc_ext = (EXT_BITS'(acc_q) << 3) + (EXT_BITS'(acc_q) << 1) + EXT_BITS'(item.digit);
		acc_lim = is_score ? SCORE_LIM : COUNT_LIM;
		acc_dig = (acc_ext > acc_lim) ? acc_lim[ACC_BITS-1:0] : acc_ext[ACC_BITS-1:0];
		extend  = (item.cls == srld_pkg::CLS_DIGIT) && (kind_q != srld_pkg::KIND_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= srld_pkg::KIND_NONE;
			acc_q       <= '0;
			digits_q    <= 1'b0;
			cur_q       <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire && item.cls != srld_pkg::CLS_NOP && !extend) begin
				out_valid_q <= emit;
			end else if (rec_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire && item.cls != srld_pkg::CLS_NOP) begin
				if (extend) begin
					acc_q    <= acc_dig;
					digits_q <= 1'b1;
				end else begin
					cur_q    <= (item.cls == srld_pkg::CLS_LOAD) ?
						ARTICLE_BITS'(item.article) : cur_fin;
					last_q   <= (item.cls == srld_pkg::CLS_EOL) ? '0 : score_fin;
					digits_q <= 1'b0;
					case (item.cls)
						srld_pkg::CLS_NEG: begin
							kind_q <= srld_pkg::KIND_NEG;
							acc_q  <= ACC_BITS'(item.digit);
						end
						srld_pkg::CLS_POS: begin
							kind_q <= srld_pkg::KIND_POS;
							acc_q  <= ACC_BITS'(item.digit);
						end
						srld_pkg::CLS_REP: begin
							kind_q <= srld_pkg::KIND_REP;
							acc_q  <= '0;
						end
						srld_pkg::CLS_SKIP: begin
							kind_q <= srld_pkg::KIND_SKIP;
							acc_q  <= '0;
						end
						default: begin
							kind_q <= srld_pkg::KIND_NONE;
							acc_q  <= '0;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !extend && emit && item.cls != srld_pkg::CLS_NOP) begin
			out_first_q <= srld_pkg::ART_FIELD_W'(cur_q);
			out_len_q   <= srld_pkg::ART_FIELD_W'(cnt);
			out_score_q <= srld_pkg::SCORE_FIELD_W'(score_fin);
		end
	end

	assign rec_valid     = out_valid_q;
	assign first_article = out_first_q;
	assign run_length    = out_len_q;
	assign score_value   = out_score_q;

endmodule

// File: design/score_run_line_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// score_run_line_decoder
// Decodes a compact score line, one character beat at a time, into run records.
// ----------------------------------------------------------------------------
// Path: the beat completing a token is registered in the front register when it
// is accepted, then written into a queue entry, and its record is then
// registered in the output register of the back.
// Throughput: one beat per cycle; the back takes a beat whenever its output
// register is free, so only master-side backpressure slows the slave side.
// Reset: arst_n clears the token state, the article number, the last score
// and all valid flags at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module score_run_line_decoder #(
	parameter int SCORE_BITS   = srld_pkg::SCORE_BITS_DEF,
	parameter int ARTICLE_BITS = srld_pkg::ARTICLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// tdata: start_article [30:0], char_code [38:31], zero pad [39]
	input  logic [srld_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// tuser: opcode [1:0]
	input  logic [srld_pkg::OP_W-1:0]          s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// tdata: first_article [30:0], run_length [61:31], score_value [93:62],
	// zero pad [95:94]
	output logic [srld_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	// The front classifies each character as soon as it is accepted, so the
	// back never needs to look at raw bytes. The queue, with its two entries,
	// lets the front keep taking beats while the back waits on the master side.

	srld_pkg::item_t front_item;
	logic            front_valid;
	logic            front_ready;
	srld_pkg::item_t back_item;
	logic            back_valid;
	logic            back_ready;

	logic [srld_pkg::ART_FIELD_W-1:0]   first_article;
	logic [srld_pkg::ART_FIELD_W-1:0]   run_length;
	logic [srld_pkg::SCORE_FIELD_W-1:0] score_value;

	srld_front #(
		.ARTICLE_BITS (ARTICLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.opcode        (s_axis_tuser),
		.start_article (s_axis_tdata[30:0]),
		.char_code     (s_axis_tdata[38:31]),
		.item_valid    (front_valid),
		.item_ready    (front_ready),
		.item          (front_item)
	);

	srld_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	// The back holds the token being built; a token completes when the next
	// non-digit character, an end of line or a start load arrives, and at
	// most one record leaves per completed token.
	srld_back #(
		.SCORE_BITS   (SCORE_BITS),
		.ARTICLE_BITS (ARTICLE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (back_valid),
		.item_ready    (back_ready),
		.item          (back_item),
		.rec_valid     (m_axis_tvalid),
		.rec_ready     (m_axis_tready),
		.first_article (first_article),
		.run_length    (run_length),
		.score_value   (score_value)
	);

	assign m_axis_tdata = {2'b00, score_value, run_length, first_article};

endmodule
